[src/assert_macros.svh]
// Assertion macros used by three RTL files of the polygon plane classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, including during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/ppc_pkg.sv]
// Package: shared types, widths and codes of the polygon plane classifier
`default_nettype none

package ppc_pkg;

  // Arithmetic widths
  localparam int COORD_W = 32;                 // coordinate bits used, Q16.16
  localparam int NORM_W  = 18;                 // normal component, Q1.16
  localparam int OFF_W   = 32;                 // plane offset, Q16.16
  localparam int EPS_W   = 31;                 // tolerance, unsigned Q15.16
  localparam int FRAC_W  = 16;                 // fraction bits of the normal
  localparam int PROD_W  = COORD_W + NORM_W;   // one coordinate product
  localparam int SUM_W   = PROD_W + 2;         // sum of three products
  localparam int DIST_W  = ((SUM_W - FRAC_W) > OFF_W ? (SUM_W - FRAC_W) : OFF_W) + 1;

  // Front pipeline depth and queue sizing
  localparam int FRONT_STAGES = 3;
  localparam int QDEPTH       = 8;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int INFL_W       = $clog2(FRONT_STAGES + 1);

  // Configuration register indexes
  localparam int REG_AW = 3;
  localparam logic [REG_AW-1:0] REG_NORMAL_X     = 3'd0;
  localparam logic [REG_AW-1:0] REG_NORMAL_Y     = 3'd1;
  localparam logic [REG_AW-1:0] REG_NORMAL_Z     = 3'd2;
  localparam logic [REG_AW-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [REG_AW-1:0] REG_EPSILON      = 3'd4;
  localparam logic [EPS_W-1:0]  EPS_RESET        = 31'd66;

  // Per-vertex side code
  typedef enum logic [1:0] {
    VC_ON     = 2'd0,
    VC_BEHIND = 2'd1,
    VC_FRONT  = 2'd2
  } vclass_t;

  // Polygon class code
  typedef enum logic [1:0] {
    SC_ON     = 2'd0,
    SC_BEHIND = 2'd1,
    SC_FRONT  = 2'd2,
    SC_SPAN   = 2'd3
  } side_class_t;

  // Plane registers seen by the front
  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic signed [OFF_W-1:0]  plane_offset;
    logic        [EPS_W-1:0]  epsilon;
  } cfg_t;

  // One classified vertex, passed front to back through the queue
  typedef struct packed {
    vclass_t vclass;
    logic    last;
  } vres_t;

endpackage

`default_nettype wire

[src/polygon_plane_classifier.sv]
// Top level: stream ports, plane registers, front pipeline, queue and back end
// Path: a last vertex's class reaches m_tvalid through the 3 front stages, the queue and
//   the output register; the first front stage loads on the edge that accepts the vertex.
// Throughput: one vertex per cycle; s_tready falls only when the 8-entry queue,
//   counted together with the up to 3 vertices in the front stages, is full.
// Reset (rst, synchronous): clears valids, queue pointers, sets the side flags and
//   loads the plane registers with normal 0, offset 0, epsilon 66.
`default_nettype none
`include "assert_macros.svh"

module polygon_plane_classifier (
  input  wire         clk,
  input  wire         rst,
  // Vertex requests
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [95:0] s_tdata,   // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
  input  wire         s_tlast,   // last_vertex
  // Class results
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // side_class [1:0], zero [7:2]
  // Configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ppc_pkg::cfg_t        cfg;
  ppc_pkg::vres_t       push_data, q_data;
  ppc_pkg::side_class_t side_class;
  logic                 push, pop, q_valid, in_valid, cfg_wr;
  logic [ppc_pkg::QAW:0]      q_count;
  logic [ppc_pkg::INFL_W-1:0] inflight;
  logic [ppc_pkg::REG_AW-1:0] reg_idx;
  logic [ppc_pkg::QAW+1:0]    credit_used;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_x     <= '0;
      cfg.normal_y     <= '0;
      cfg.normal_z     <= '0;
      cfg.plane_offset <= '0;
      cfg.epsilon      <= ppc_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ppc_pkg::REG_NORMAL_X:     cfg.normal_x     <= pwdata[ppc_pkg::NORM_W-1:0];
        ppc_pkg::REG_NORMAL_Y:     cfg.normal_y     <= pwdata[ppc_pkg::NORM_W-1:0];
        ppc_pkg::REG_NORMAL_Z:     cfg.normal_z     <= pwdata[ppc_pkg::NORM_W-1:0];
        ppc_pkg::REG_PLANE_OFFSET: cfg.plane_offset <= pwdata[ppc_pkg::OFF_W-1:0];
        ppc_pkg::REG_EPSILON:      cfg.epsilon      <= pwdata[ppc_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      ppc_pkg::REG_NORMAL_X:     prdata = 32'(unsigned'(cfg.normal_x));
      ppc_pkg::REG_NORMAL_Y:     prdata = 32'(unsigned'(cfg.normal_y));
      ppc_pkg::REG_NORMAL_Z:     prdata = 32'(unsigned'(cfg.normal_z));
      ppc_pkg::REG_PLANE_OFFSET: prdata = 32'(unsigned'(cfg.plane_offset));
      ppc_pkg::REG_EPSILON:      prdata = 32'(cfg.epsilon);
      default:                   prdata = '0;
    endcase
  end

  // Input credit: queue entries plus vertices still in the front stages
  assign credit_used = (ppc_pkg::QAW + 2)'(q_count) + (ppc_pkg::QAW + 2)'(inflight);
  assign s_tready    = credit_used < (ppc_pkg::QAW + 2)'(ppc_pkg::QDEPTH);
  assign in_valid    = s_tvalid && s_tready;

  ppc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .vx        (s_tdata[31:0]),
    .vy        (s_tdata[63:32]),
    .vz        (s_tdata[95:64]),
    .in_last   (s_tlast),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .inflight  (inflight)
  );

  ppc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .count     (q_count)
  );

  ppc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .side_class (side_class)
  );

  assign m_tdata = {6'b0, side_class};

  `ASSERT_CLK(a_credit, credit_used <= (ppc_pkg::QAW + 2)'(ppc_pkg::QDEPTH), "queue credit exceeded")

endmodule

`default_nettype wire

[src/ppc_front.sv]
// Front: three-stage distance pipeline that classifies each vertex against the plane
`default_nettype none

module ppc_front (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire  [ppc_pkg::COORD_W-1:0]     vx,
  input  wire  [ppc_pkg::COORD_W-1:0]     vy,
  input  wire  [ppc_pkg::COORD_W-1:0]     vz,
  input  wire                             in_last,
  input  wire  ppc_pkg::cfg_t             cfg,
  output logic                            push,
  output ppc_pkg::vres_t                  push_data,
  output logic [ppc_pkg::INFL_W-1:0]      inflight
);

  // Stage valids and last marks
  logic v1, v2, v3;
  logic l1, l2, l3;

  // Stage payloads
  logic signed [ppc_pkg::PROD_W-1:0] p1_x, p1_y, p1_z;
  logic signed [ppc_pkg::SUM_W-1:0]  s2;
  logic signed [ppc_pkg::DIST_W-1:0] d3;

  logic signed [ppc_pkg::COORD_W-1:0] sx, sy, sz;
  logic signed [ppc_pkg::DIST_W-1:0]  eps_pos, eps_neg;

  assign sx = $signed(vx);
  assign sy = $signed(vy);
  assign sz = $signed(vz);

  // Control: the pipeline always advances, the queue credit keeps room for it
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: products, stage 2: sum, stage 3: scale back and add offset
  always_ff @(posedge clk) begin
    p1_x <= sx * cfg.normal_x;
    p1_y <= sy * cfg.normal_y;
    p1_z <= sz * cfg.normal_z;
    l1   <= in_last;
    s2   <= ppc_pkg::SUM_W'(p1_x) + ppc_pkg::SUM_W'(p1_y) + ppc_pkg::SUM_W'(p1_z);
    l2   <= l1;
    d3   <= ppc_pkg::DIST_W'(s2 >>> ppc_pkg::FRAC_W) + ppc_pkg::DIST_W'(cfg.plane_offset);
    l3   <= l2;
  end

  // Tolerance band compare
  assign eps_pos = $signed(ppc_pkg::DIST_W'(cfg.epsilon));
  assign eps_neg = -eps_pos;

  always_comb begin
    push           = v3;
    push_data.last = l3;
    if (d3 > eps_pos) begin
      push_data.vclass = ppc_pkg::VC_FRONT;
    end else if (d3 < eps_neg) begin
      push_data.vclass = ppc_pkg::VC_BEHIND;
    end else begin
      push_data.vclass = ppc_pkg::VC_ON;
    end
  end

  assign inflight = ppc_pkg::INFL_W'(v1) + ppc_pkg::INFL_W'(v2) + ppc_pkg::INFL_W'(v3);

endmodule

`default_nettype wire

[src/ppc_queue.sv]
// Queue: small first-word-fall-through buffer of classified vertices
`default_nettype none
`include "assert_macros.svh"

module ppc_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire  ppc_pkg::vres_t         push_data,
  input  wire                          pop,
  output logic                         q_valid,
  output ppc_pkg::vres_t               q_data,
  output logic [ppc_pkg::QAW:0]        count
);

  ppc_pkg::vres_t            q_mem [ppc_pkg::QDEPTH];
  logic [ppc_pkg::QAW-1:0]   wr_ptr, rd_ptr;
  logic                      full;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (ppc_pkg::QAW + 1)'(push) - (ppc_pkg::QAW + 1)'(pop);
    end
  end

  assign q_valid = (count != '0);
  assign q_data  = q_mem[rd_ptr];
  assign full    = (count == (ppc_pkg::QAW + 1)'(ppc_pkg::QDEPTH));

  `ASSERT_CLK(a_no_overflow, push |-> (!full || pop), "queue push while full")
  `ASSERT_CLK(a_no_underflow, pop |-> q_valid, "queue pop while empty")

endmodule

`default_nettype wire

[src/ppc_back.sv]
// Back: sticky side flags and the registered polygon class output
`default_nettype none
`include "assert_macros.svh"

module ppc_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  input  wire  ppc_pkg::vres_t  q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output ppc_pkg::side_class_t  side_class
);

  logic all_on_plane, all_behind_or_on, all_front_or_on;
  logic on_next, behind_next, front_next;
  logic pop_last;
  ppc_pkg::side_class_t class_next;

  // A non-last vertex always drains; a last one needs the output slot
  assign pop      = q_valid && (!q_data.last || !out_valid || out_ready);
  assign pop_last = pop && q_data.last;

  // Flag update and class selection
  always_comb begin
    on_next     = all_on_plane && (q_data.vclass == ppc_pkg::VC_ON);
    behind_next = all_behind_or_on && (q_data.vclass != ppc_pkg::VC_FRONT);
    front_next  = all_front_or_on && (q_data.vclass != ppc_pkg::VC_BEHIND);
    priority if (on_next) begin
      class_next = ppc_pkg::SC_ON;
    end else if (behind_next) begin
      class_next = ppc_pkg::SC_BEHIND;
    end else if (front_next) begin
      class_next = ppc_pkg::SC_FRONT;
    end else begin
      class_next = ppc_pkg::SC_SPAN;
    end
  end

  // Sticky flags, re-armed after each polygon
  always_ff @(posedge clk) begin
    if (rst) begin
      all_on_plane     <= 1'b1;
      all_behind_or_on <= 1'b1;
      all_front_or_on  <= 1'b1;
    end else if (pop_last) begin
      all_on_plane     <= 1'b1;
      all_behind_or_on <= 1'b1;
      all_front_or_on  <= 1'b1;
    end else if (pop) begin
      all_on_plane     <= on_next;
      all_behind_or_on <= behind_next;
      all_front_or_on  <= front_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      side_class <= class_next;
    end
  end

  `ASSERT_CLK(a_result_from_last, $rose(out_valid) |-> $past(pop_last), "result without a last vertex")
  `ASSERT_CLK(a_no_drop, (out_valid && !out_ready) |-> !pop_last, "result overwritten while stalled")

endmodule

`default_nettype wire

[tb/sv/polygon_plane_classifier_tb.sv]
// Testbench for polygon_plane_classifier: directed and random polygons vs a plane predictor
`timescale 1ns / 1ps

module polygon_plane_classifier_tb;

  localparam int SETTLE_CYCLES  = 10;     // extra wait once every class has come out
  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no request moving
  localparam int PHASE_ITEMS    = 330;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Vertex stream
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;   // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
  logic        s_tlast  = 1'b0; // last_vertex

  // Class stream
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // side_class [1:0], zero [7:2]

  // Register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  polygon_plane_classifier u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Plane registers as the block should hold them
  logic signed [ppc_pkg::NORM_W-1:0] plane_nx  = '0;
  logic signed [ppc_pkg::NORM_W-1:0] plane_ny  = '0;
  logic signed [ppc_pkg::NORM_W-1:0] plane_nz  = '0;
  logic signed [ppc_pkg::OFF_W-1:0]  plane_off = '0;
  logic        [ppc_pkg::EPS_W-1:0]  plane_eps = ppc_pkg::EPS_RESET;

  // Sticky side flags of the polygon in progress
  logic flag_on          = 1'b1;
  logic flag_behind_or_on = 1'b1;
  logic flag_front_or_on = 1'b1;

  ppc_pkg::side_class_t expected_classes[$];
  ppc_pkg::side_class_t want_class;

  int errors       = 0;
  int sent_items   = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 66;

  // Signed distance of a vertex from the plane, Q16.16, exact
  function automatic longint plane_distance(input logic signed [31:0] vx,
                                            input logic signed [31:0] vy,
                                            input logic signed [31:0] vz);
    longint dot;
    dot = longint'(vx) * longint'(plane_nx) + longint'(vy) * longint'(plane_ny)
        + longint'(vz) * longint'(plane_nz);
    return (dot >>> ppc_pkg::FRAC_W) + longint'(plane_off);
  endfunction

  // Fold one vertex into the flags; a last vertex yields the polygon class
  function automatic void fold_vertex(input logic [95:0] data, input logic last);
    longint vdist;
    longint eps;
    vdist = plane_distance($signed(data[31:0]), $signed(data[63:32]), $signed(data[95:64]));
    eps   = longint'(plane_eps);
    if (vdist > eps) begin
      flag_on           = 1'b0;
      flag_behind_or_on = 1'b0;
    end else if (vdist < -eps) begin
      flag_on          = 1'b0;
      flag_front_or_on = 1'b0;
    end
    if (last) begin
      if (flag_on) expected_classes.push_back(ppc_pkg::SC_ON);
      else if (flag_behind_or_on) expected_classes.push_back(ppc_pkg::SC_BEHIND);
      else if (flag_front_or_on) expected_classes.push_back(ppc_pkg::SC_FRONT);
      else expected_classes.push_back(ppc_pkg::SC_SPAN);
      flag_on           = 1'b1;
      flag_behind_or_on = 1'b1;
      flag_front_or_on  = 1'b1;
    end
  endfunction

  // Send one vertex request, with a random gap before it
  task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {vz, vy, vx};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    fold_vertex({vz, vy, vx}, last);
    sent_items++;
  endtask

  // Stop sending and wait until every class has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup then access; bus released only after the final one
  task automatic write_reg(input logic [ppc_pkg::REG_AW-1:0] idx, input logic [31:0] value,
                           input logic final_write);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ppc_pkg::REG_NORMAL_X:     plane_nx  = value[ppc_pkg::NORM_W-1:0];
      ppc_pkg::REG_NORMAL_Y:     plane_ny  = value[ppc_pkg::NORM_W-1:0];
      ppc_pkg::REG_NORMAL_Z:     plane_nz  = value[ppc_pkg::NORM_W-1:0];
      ppc_pkg::REG_PLANE_OFFSET: plane_off = value[ppc_pkg::OFF_W-1:0];
      ppc_pkg::REG_EPSILON:      plane_eps = value[ppc_pkg::EPS_W-1:0];
      default: ;
    endcase
    if (final_write) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic configure_plane(input logic [31:0] nx, input logic [31:0] ny,
                                 input logic [31:0] nz, input logic [31:0] off,
                                 input logic [31:0] eps);
    settle();
    write_reg(ppc_pkg::REG_NORMAL_X, nx, 1'b0);
    write_reg(ppc_pkg::REG_NORMAL_Y, ny, 1'b0);
    write_reg(ppc_pkg::REG_NORMAL_Z, nz, 1'b0);
    write_reg(ppc_pkg::REG_PLANE_OFFSET, off, 1'b0);
    write_reg(ppc_pkg::REG_EPSILON, eps, 1'b1);
  endtask

  // ---------------- random values ----------------

  function automatic logic [31:0] random_normal();
    case ($urandom_range(5))
      0:       return 32'(-65536);
      1:       return 32'(65536);
      2:       return $urandom();                    // any 18-bit pattern
      3:       return '0;
      default: return 32'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] random_coord(input int mode);
    case (mode)
      0:       return $urandom();
      1:       return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      2:       return 32'(int'($urandom_range(0, 2048)) - 1024);
      3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return '0;
    endcase
  endfunction

  task automatic randomize_plane();
    logic [31:0] off;
    logic [31:0] eps;
    case ($urandom_range(3))
      0:       off = $urandom();
      1:       off = '0;
      default: off = 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
    case ($urandom_range(5))
      0:       eps = '0;
      1:       eps = 32'h7fff_ffff;
      2:       eps = $urandom();
      3:       eps = $urandom_range(0, 1 << 20);
      default: eps = $urandom_range(0, 4096);
    endcase
    configure_plane(random_normal(), random_normal(), random_normal(), off, eps);
  endtask

  task automatic send_random_polygon();
    int n;
    int mode;
    n    = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    mode = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      // most polygons keep one coordinate style, some mix per vertex
      if ($urandom_range(4) == 0) mode = $urandom_range(4);
      send_vertex(random_coord(mode), random_coord(mode), random_coord(mode), i == n - 1);
    end
  endtask

  // ---------------- tests ----------------

  // Reset registers: zero normal and offset, so every vertex lies on the plane
  task automatic test_reset_defaults();
    send_vertex($urandom(), $urandom(), $urandom(), 1'b1);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, $urandom(), 1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, $urandom(), 1'b1);
  endtask

  // Distance exactly at the band edges, one past them, and floor of a negative half
  task automatic test_band_edges();
    configure_plane(32'h0001_0000, '0, '0, '0, 32'd100);
    send_vertex(32'd100, '0, '0, 1'b1);
    send_vertex(32'(-100), '0, '0, 1'b1);
    send_vertex(32'd101, '0, '0, 1'b1);
    send_vertex(32'(-101), '0, '0, 1'b1);
    configure_plane(32'h0000_8000, '0, '0, '0, '0);
    send_vertex(32'hffff_ffff, '0, '0, 1'b1);
  endtask

  // Class priority when several flags survive
  task automatic test_class_priority();
    configure_plane(32'h0001_0000, '0, '0, '0, 32'd10);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(32'(-50), '0, '0, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(32'd50, '0, '0, 1'b1);
    send_vertex(32'd50, '0, '0, 1'b0);
    send_vertex(32'(-50), '0, '0, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex('0, '0, '0, 1'b1);
  endtask

  // Full-range coordinates, normals outside +-1.0, offset and epsilon extremes
  task automatic test_extremes();
    configure_plane(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h7fff_ffff, '0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    configure_plane(32'h0001_ffff, 32'h0001_ffff, 32'h0001_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_vertex('0, '0, '0, 1'b1);
    configure_plane(32'h0001_0000, 32'(-65536), 32'h0001_0000, '0, '0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
  endtask

  // Writes above the last register must not touch any register
  task automatic test_unmapped_regs();
    configure_plane(32'h0001_0000, '0, '0, '0, '0);
    // the bus goes idle before the next setup phase
    @(posedge clk);
    for (int i = int'(ppc_pkg::REG_EPSILON) + 1; i < 2 ** ppc_pkg::REG_AW; i++)
      write_reg(ppc_pkg::REG_AW'(i), 32'hffff_ffff, i == 2 ** ppc_pkg::REG_AW - 1);
    send_vertex(32'h0001_0000, '0, '0, 1'b1);
  endtask

  task automatic test_random_polygons(input int n_items, input int s_idle, input int r_idle);
    int target;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = sent_items + n_items;
    randomize_plane();
    while (sent_items < target) begin
      if ($urandom_range(19) == 0) randomize_plane();
      else if ($urandom_range(29) == 0) settle();
      send_random_polygon();
    end
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_classes.size() == 0) begin
        $display("%0t: class result with none expected: expected none, actual %0d",
                 $time, m_tdata);
        errors++;
      end else begin
        want_class = expected_classes.pop_front();
        if (m_tdata != {6'd0, want_class}) begin
          $display("%0t: side_class mismatch: expected %0d, actual %0d",
                   $time, {6'd0, want_class}, m_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in which no request moves on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL polygon_plane_classifier");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_band_edges();
    test_class_priority();
    test_extremes();
    test_unmapped_regs();
    test_random_polygons(PHASE_ITEMS, 27, 66);
    test_random_polygons(PHASE_ITEMS, 66, 27);
    test_random_polygons(PHASE_ITEMS, 0, 0);
    settle();
    errors += expected_classes.size();
    if (errors == 0) begin
      $display("PASS polygon_plane_classifier");
    end else begin
      $display("FAIL polygon_plane_classifier");
    end
    $finish;
  end

endmodule
